[rtl/core/page_map_allocator_core_defines.svh]
`ifndef PAGE_MAP_ALLOCATOR_CORE_DEFINES_SVH
`define PAGE_MAP_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PMA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page map allocator: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PMA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page map allocator: next-cycle check failed");

`endif

[rtl/core/pma_pkg.sv]
package pma_pkg;

    localparam int TASKS  = 16;
    localparam int VPAGES = 1024;
    localparam int FRAMES = 4096;

    localparam int TASK_W  = 4;
    localparam int PAGE_W  = 10;
    localparam int COUNT_W = 11;
    localparam int FRAME_W = 13;
    localparam int STAT_W  = 32;

    localparam int TASK_IW  = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int ROW_BITS = 16;
    localparam int BIT_W    = 4;
    localparam int ROWS     = TASKS * VPAGES / ROW_BITS;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LIN_W    = ROW_W + BIT_W;
    localparam int RNG_W    = 17;

    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic [ROW_W-1:0]    addr;
        logic [ROW_BITS-1:0] wr_data;
    } vt_ctl_t;

endpackage

[rtl/core/pma_if.sv]
interface pma_req_if;
    logic                         valid;
    logic                         ready;
    logic [pma_pkg::TASK_W-1:0]   task_id;
    logic [pma_pkg::PAGE_W-1:0]   start_page;
    logic [pma_pkg::COUNT_W-1:0]  page_count;

    modport source (output valid, task_id, start_page, page_count, input ready);
    modport sink   (input valid, task_id, start_page, page_count, output ready);
endinterface

interface pma_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [pma_pkg::FRAME_W-1:0]  first_frame;
    logic [pma_pkg::COUNT_W-1:0]  hit_count;
    logic [pma_pkg::COUNT_W-1:0]  miss_count;
    logic                         memory_full;
    logic                         range_error;
    logic [pma_pkg::STAT_W-1:0]   task_hits;
    logic [pma_pkg::STAT_W-1:0]   task_misses;
    logic [pma_pkg::STAT_W-1:0]   all_hits;
    logic [pma_pkg::STAT_W-1:0]   all_misses;

    modport source (output valid, first_frame, hit_count, miss_count, memory_full,
                    range_error, task_hits, task_misses, all_hits, all_misses,
                    input ready);
    modport sink   (input valid, first_frame, hit_count, miss_count, memory_full,
                    range_error, task_hits, task_misses, all_hits, all_misses,
                    output ready);
endinterface

[rtl/core/pma_vtable.sv]
module pma_vtable (
    input  logic                             clk,
    input  pma_pkg::vt_ctl_t                 ctl,
    output logic [pma_pkg::ROW_BITS-1:0]     rd_data
);

    logic [pma_pkg::ROW_BITS-1:0] mem_reg [pma_pkg::ROWS];
    logic [pma_pkg::ROW_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_reg[ctl.addr] <= ctl.wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem_reg[ctl.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/page_map_allocator_core.sv]
// Channel  Dir  Transfer when           Payload
// req      in   req.valid & req.ready   task_id, start_page, page_count
// rsp      out  rsp.valid & rsp.ready   first_frame .. all_misses
// cfg      in   cfg_we                  cfg_wdata (frame_limit)
//
// Per page, a request reads the valid-bit row and, on a miss with a free frame,
// writes it back over the single table port; a refused or empty request skips
// the page steps. The shared saturating adder updates the four running counters in turn.
// After reset the valid-bit table is cleared one row a cycle, all 1024 rows,
// with req.ready low. A stalled rsp holds the result; a new request is taken
// meanwhile and waits for the output register only at its end.
module page_map_allocator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pma_pkg::FRAME_W-1:0]   cfg_wdata,
    pma_req_if.sink                       req,
    pma_rsp_if.source                     rsp
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_ACC,
        ST_OUT
    } state_t;

    state_t                          state_reg;
    logic [pma_pkg::ROW_W-1:0]       clr_row_reg;
    logic [pma_pkg::FRAME_W-1:0]     frame_limit_reg;
    logic [pma_pkg::FRAME_W-1:0]     next_free_reg;
    logic [pma_pkg::TASK_W-1:0]      task_reg;
    logic                            task_ok_reg;
    logic [pma_pkg::LIN_W-1:0]       lin_reg;
    logic [pma_pkg::COUNT_W-1:0]     remain_reg;
    logic [pma_pkg::FRAME_W-1:0]     first_reg;
    logic [pma_pkg::COUNT_W-1:0]     hits_reg;
    logic [pma_pkg::COUNT_W-1:0]     misses_reg;
    logic                            full_reg;
    logic                            rerr_reg;
    logic [1:0]                      step_reg;
    logic [pma_pkg::STAT_W-1:0]      task_hits_reg   [pma_pkg::TASKS];
    logic [pma_pkg::STAT_W-1:0]      task_misses_reg [pma_pkg::TASKS];
    logic [pma_pkg::STAT_W-1:0]      all_hits_reg;
    logic [pma_pkg::STAT_W-1:0]      all_misses_reg;

    logic                            rsp_valid_reg;
    logic [pma_pkg::FRAME_W-1:0]     rsp_first_reg;
    logic [pma_pkg::COUNT_W-1:0]     rsp_hits_reg;
    logic [pma_pkg::COUNT_W-1:0]     rsp_misses_reg;
    logic                            rsp_full_reg;
    logic                            rsp_rerr_reg;
    logic [pma_pkg::STAT_W-1:0]      rsp_task_hits_reg;
    logic [pma_pkg::STAT_W-1:0]      rsp_task_misses_reg;
    logic [pma_pkg::STAT_W-1:0]      rsp_all_hits_reg;
    logic [pma_pkg::STAT_W-1:0]      rsp_all_misses_reg;

    logic [pma_pkg::TASK_IW-1:0]     tidx;
    logic [pma_pkg::FRAME_W-1:0]     limit;
    logic                            can_alloc;
    logic                            req_task_ok;
    logic                            req_over;
    logic                            req_rerr;
    logic [pma_pkg::LIN_W-1:0]       req_lin;
    logic [pma_pkg::ROW_BITS-1:0]    vt_rd_data;
    logic [pma_pkg::ROW_BITS-1:0]    bit_mask;
    logic                            page_valid;
    pma_pkg::vt_ctl_t                vt_ctl;
    logic [pma_pkg::STAT_W-1:0]      acc_a;
    logic [pma_pkg::COUNT_W-1:0]     acc_b;
    logic [pma_pkg::STAT_W:0]        acc_sum;
    logic [pma_pkg::STAT_W-1:0]      acc_next;
    logic                            rsp_load;

    assign tidx = pma_pkg::TASK_IW'(task_reg);
    assign limit = (frame_limit_reg > pma_pkg::FRAME_W'(pma_pkg::FRAMES))
                 ? pma_pkg::FRAME_W'(pma_pkg::FRAMES) : frame_limit_reg;
    assign can_alloc = (next_free_reg < limit);

    assign req_task_ok = (pma_pkg::RNG_W'(req.task_id) < pma_pkg::RNG_W'(pma_pkg::TASKS));
    assign req_over    = ((pma_pkg::RNG_W'(req.start_page) + pma_pkg::RNG_W'(req.page_count))
                         > pma_pkg::RNG_W'(pma_pkg::VPAGES));
    assign req_rerr    = !req_task_ok || req_over;
    assign req_lin     = pma_pkg::LIN_W'(32'(req.task_id) * 32'(pma_pkg::VPAGES)
                                         + 32'(req.start_page));

    assign bit_mask   = pma_pkg::ROW_BITS'(1) << lin_reg[pma_pkg::BIT_W-1:0];
    assign page_valid = |(vt_rd_data & bit_mask);

    assign rsp_load = (state_reg == ST_OUT) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        vt_ctl.rd_en   = 1'b0;
        vt_ctl.wr_en   = 1'b0;
        vt_ctl.addr    = lin_reg[pma_pkg::LIN_W-1:pma_pkg::BIT_W];
        vt_ctl.wr_data = vt_rd_data | bit_mask;
        unique case (state_reg)
            ST_CLEAR:
            begin
                vt_ctl.wr_en   = 1'b1;
                vt_ctl.addr    = clr_row_reg;
                vt_ctl.wr_data = '0;
            end
            ST_READ:  vt_ctl.rd_en = 1'b1;
            ST_CHECK: vt_ctl.wr_en = !page_valid && can_alloc;
            ST_IDLE, ST_ACC, ST_OUT: ;
        endcase
    end

    pma_vtable u_vtable (
        .clk     (clk),
        .ctl     (vt_ctl),
        .rd_data (vt_rd_data)
    );

    always_comb
    begin
        unique case (step_reg)
            2'd0: acc_a = task_hits_reg[tidx];
            2'd1: acc_a = task_misses_reg[tidx];
            2'd2: acc_a = all_hits_reg;
            2'd3: acc_a = all_misses_reg;
        endcase
    end

    assign acc_b    = step_reg[0] ? misses_reg : hits_reg;
    assign acc_sum  = {1'b0, acc_a} + (pma_pkg::STAT_W + 1)'(acc_b);
    assign acc_next = acc_sum[pma_pkg::STAT_W] ? '1 : acc_sum[pma_pkg::STAT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_row_reg     <= '0;
            frame_limit_reg <= pma_pkg::FRAME_W'(pma_pkg::FRAMES);
            next_free_reg   <= '0;
            task_reg        <= '0;
            task_ok_reg     <= 1'b0;
            lin_reg         <= '0;
            remain_reg      <= '0;
            first_reg       <= '0;
            hits_reg        <= '0;
            misses_reg      <= '0;
            full_reg        <= 1'b0;
            rerr_reg        <= 1'b0;
            step_reg        <= '0;
            for (int i = 0; i < pma_pkg::TASKS; i++)
            begin
                task_hits_reg[i]   <= '0;
                task_misses_reg[i] <= '0;
            end
            all_hits_reg        <= '0;
            all_misses_reg      <= '0;
            rsp_valid_reg       <= 1'b0;
            rsp_first_reg       <= '0;
            rsp_hits_reg        <= '0;
            rsp_misses_reg      <= '0;
            rsp_full_reg        <= 1'b0;
            rsp_rerr_reg        <= 1'b0;
            rsp_task_hits_reg   <= '0;
            rsp_task_misses_reg <= '0;
            rsp_all_hits_reg    <= '0;
            rsp_all_misses_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                frame_limit_reg <= cfg_wdata;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_row_reg <= clr_row_reg + 1'b1;
                    if (clr_row_reg == pma_pkg::ROW_W'(pma_pkg::ROWS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        task_reg    <= req.task_id;
                        task_ok_reg <= req_task_ok;
                        lin_reg     <= req_lin;
                        remain_reg  <= req.page_count;
                        first_reg   <= next_free_reg;
                        hits_reg    <= '0;
                        misses_reg  <= '0;
                        full_reg    <= 1'b0;
                        rerr_reg    <= req_rerr;
                        step_reg    <= '0;
                        if (req_rerr || (req.page_count == '0))
                        begin
                            state_reg <= ST_ACC;
                        end
                        else
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    priority if (page_valid)
                    begin
                        hits_reg <= hits_reg + 1'b1;
                    end
                    else if (can_alloc)
                    begin
                        next_free_reg <= next_free_reg + 1'b1;
                        misses_reg    <= misses_reg + 1'b1;
                    end
                    else
                    begin
                        full_reg <= 1'b1;
                    end
                    lin_reg    <= lin_reg + 1'b1;
                    remain_reg <= remain_reg - 1'b1;
                    state_reg  <= (remain_reg == pma_pkg::COUNT_W'(1)) ? ST_ACC : ST_READ;
                end
                ST_ACC:
                begin
                    unique case (step_reg)
                        2'd0:
                        begin
                            if (task_ok_reg)
                            begin
                                task_hits_reg[tidx] <= acc_next;
                            end
                        end
                        2'd1:
                        begin
                            if (task_ok_reg)
                            begin
                                task_misses_reg[tidx] <= acc_next;
                            end
                        end
                        2'd2: all_hits_reg   <= acc_next;
                        2'd3: all_misses_reg <= acc_next;
                    endcase
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 2'd3)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (rsp_load)
                    begin
                        rsp_first_reg       <= first_reg;
                        rsp_hits_reg        <= hits_reg;
                        rsp_misses_reg      <= misses_reg;
                        rsp_full_reg        <= full_reg;
                        rsp_rerr_reg        <= rerr_reg;
                        rsp_task_hits_reg   <= task_ok_reg ? task_hits_reg[tidx] : '0;
                        rsp_task_misses_reg <= task_ok_reg ? task_misses_reg[tidx] : '0;
                        rsp_all_hits_reg    <= all_hits_reg;
                        rsp_all_misses_reg  <= all_misses_reg;
                        state_reg           <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.first_frame = rsp_first_reg;
    assign rsp.hit_count   = rsp_hits_reg;
    assign rsp.miss_count  = rsp_misses_reg;
    assign rsp.memory_full = rsp_full_reg;
    assign rsp.range_error = rsp_rerr_reg;
    assign rsp.task_hits   = rsp_task_hits_reg;
    assign rsp.task_misses = rsp_task_misses_reg;
    assign rsp.all_hits    = rsp_all_hits_reg;
    assign rsp.all_misses  = rsp_all_misses_reg;

endmodule

[rtl/core/pma_checker.sv]
`include "page_map_allocator_core_defines.svh"

module pma_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  logic [pma_pkg::FRAME_W-1:0]   first_frame,
    input  logic [pma_pkg::COUNT_W-1:0]   hit_count,
    input  logic [pma_pkg::COUNT_W-1:0]   miss_count,
    input  logic                          memory_full,
    input  logic                          range_error,
    input  logic [pma_pkg::STAT_W-1:0]    all_hits,
    input  logic [pma_pkg::STAT_W-1:0]    all_misses
);

    `PMA_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
    `PMA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(first_frame) && $stable(all_misses))
    `PMA_ASSERT_SAME(a_refused_empty, rsp_valid && range_error, hit_count == '0 && miss_count == '0 && !memory_full)
    `PMA_ASSERT_SAME(a_counts_in_totals, rsp_valid, 32'(miss_count) <= all_misses && 32'(hit_count) <= all_hits)

endmodule

bind page_map_allocator_core pma_checker u_pma_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .first_frame (rsp.first_frame),
    .hit_count   (rsp.hit_count),
    .miss_count  (rsp.miss_count),
    .memory_full (rsp.memory_full),
    .range_error (rsp.range_error),
    .all_hits    (rsp.all_hits),
    .all_misses  (rsp.all_misses)
);
